[hdl/lpfc_pkg.sv]
// shared types, constants and register indexes of the length-prefixed frame checker
// no dependencies; used by every module under hdl
package lpfc_pkg;

   localparam int unsigned MAX_TOTAL_BYTES_VAL = 65536;
   localparam int unsigned TOTAL_W            = $clog2(MAX_TOTAL_BYTES_VAL + 2);
   localparam logic [TOTAL_W-1:0] MAX_TOTAL_BYTES = TOTAL_W'(MAX_TOTAL_BYTES_VAL);

   localparam int unsigned LEN_FIELD_BYTES = 4;
   localparam int unsigned LEN_CNT_W       = $clog2(LEN_FIELD_BYTES);
   localparam logic [LEN_CNT_W-1:0] LEN_CNT_LAST = LEN_CNT_W'(LEN_FIELD_BYTES - 1);
   localparam int unsigned LEN_W           = 8 * LEN_FIELD_BYTES;

   localparam int unsigned PART_W    = 3;
   localparam logic [PART_W-1:0] MAX_PARTS = PART_W'(4);
   localparam int unsigned TABLE_DEPTH = 4;
   localparam int unsigned TABLE_IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned EXP_LEN_W   = 17;

   // configuration port
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = EXP_LEN_W;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_PART_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_PART_LENGTHS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_LEN_0      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_LEN_1      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_LEN_2      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_LEN_3      = 3'd5;

   // status codes
   localparam logic [1:0] ST_VALID       = 2'd0;
   localparam logic [1:0] ST_INVALID_ARG = 2'd1;
   localparam logic [1:0] ST_BAD_FORMAT  = 2'd2;
   localparam logic [1:0] ST_UNUSED      = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [PART_W-1:0] parts_seen;
   } rsp_type;

   typedef struct packed {
      logic [PART_W-1:0]                      expected_part_count;
      logic                                   check_part_lengths;
      logic [TABLE_DEPTH-1:0][EXP_LEN_W-1:0]  expected_len;
   } cfg_type;

endpackage

[hdl/lpfc_cfg_regs.sv]
// configuration register file of the length-prefixed frame checker
// depends on lpfc_pkg
module lpfc_cfg_regs (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [lpfc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lpfc_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output lpfc_pkg::cfg_type                  cfg
);

   lpfc_pkg::cfg_type cfg_ff;
   lpfc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lpfc_pkg::CSR_EXPECTED_PART_COUNT: begin
               cfg_in.expected_part_count = csr_wdata[lpfc_pkg::PART_W-1:0];
            end
            lpfc_pkg::CSR_CHECK_PART_LENGTHS: begin
               cfg_in.check_part_lengths = csr_wdata[0];
            end
            lpfc_pkg::CSR_EXPECTED_LEN_0: begin
               cfg_in.expected_len[0] = csr_wdata[lpfc_pkg::EXP_LEN_W-1:0];
            end
            lpfc_pkg::CSR_EXPECTED_LEN_1: begin
               cfg_in.expected_len[1] = csr_wdata[lpfc_pkg::EXP_LEN_W-1:0];
            end
            lpfc_pkg::CSR_EXPECTED_LEN_2: begin
               cfg_in.expected_len[2] = csr_wdata[lpfc_pkg::EXP_LEN_W-1:0];
            end
            lpfc_pkg::CSR_EXPECTED_LEN_3: begin
               cfg_in.expected_len[3] = csr_wdata[lpfc_pkg::EXP_LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_part_count <= lpfc_pkg::PART_W'(1);
         cfg_ff.check_part_lengths  <= 1'b0;
         cfg_ff.expected_len        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/lpfc_parser.sv]
// per-byte record parser: length fields, payload countdown, error and total tracking
// depends on lpfc_pkg
module lpfc_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  lpfc_pkg::req_type   item,
   input  lpfc_pkg::cfg_type   cfg,
   output lpfc_pkg::rsp_type   result
);

   logic                              in_payload_ff, in_payload_in;
   logic [lpfc_pkg::LEN_CNT_W-1:0]    len_cnt_ff, len_cnt_in;
   logic [lpfc_pkg::LEN_W-1:0]        len_acc_ff, len_acc_in;
   logic [lpfc_pkg::LEN_W-1:0]        pay_left_ff, pay_left_in;
   logic [lpfc_pkg::PART_W-1:0]       part_idx_ff, part_idx_in;
   logic [lpfc_pkg::TOTAL_W-1:0]      total_ff, total_in;
   logic                              fmt_err_ff, fmt_err_in;

   logic [lpfc_pkg::LEN_W-1:0]        len_full;
   logic [lpfc_pkg::LEN_W-1:0]        pay_dec;
   logic [lpfc_pkg::EXP_LEN_W-1:0]    tbl_len;
   logic                              bad_arg;

   always_comb begin
      // parts without a table entry compare against zero
      if (part_idx_ff < lpfc_pkg::PART_W'(lpfc_pkg::TABLE_DEPTH)) begin
         tbl_len = cfg.expected_len[part_idx_ff[lpfc_pkg::TABLE_IDX_W-1:0]];
      end else begin
         tbl_len = '0;
      end
   end

   assign len_full = len_acc_ff |
                     ({{(lpfc_pkg::LEN_W-8){1'b0}}, item.data_byte} << {len_cnt_ff, 3'b000});
   assign pay_dec  = pay_left_ff - lpfc_pkg::LEN_W'(1);

   always_comb begin
      in_payload_in = in_payload_ff;
      len_cnt_in    = len_cnt_ff;
      len_acc_in    = len_acc_ff;
      pay_left_in   = pay_left_ff;
      part_idx_in   = part_idx_ff;
      fmt_err_in    = fmt_err_ff;

      // saturating byte count
      if (total_ff <= lpfc_pkg::MAX_TOTAL_BYTES) begin
         total_in = total_ff + lpfc_pkg::TOTAL_W'(1);
      end else begin
         total_in = total_ff;
      end

      if (!fmt_err_ff) begin
         if (in_payload_ff) begin
            pay_left_in = pay_dec;
            if (pay_dec == '0) begin
               in_payload_in = 1'b0;
            end else if (item.last_byte) begin
               fmt_err_in = 1'b1;
            end
         end else if (part_idx_ff == cfg.expected_part_count) begin
            // leftover bytes
            fmt_err_in = 1'b1;
         end else begin
            len_acc_in = len_full;
            len_cnt_in = len_cnt_ff + lpfc_pkg::LEN_CNT_W'(1);
            if (len_cnt_ff == lpfc_pkg::LEN_CNT_LAST) begin
               len_cnt_in  = '0;
               part_idx_in = part_idx_ff + lpfc_pkg::PART_W'(1);
               len_acc_in  = '0;
               if (len_full == '0) begin
                  fmt_err_in = 1'b1;
               end else if (cfg.check_part_lengths &&
                            len_full != lpfc_pkg::LEN_W'(tbl_len)) begin
                  fmt_err_in = 1'b1;
               end else if (item.last_byte) begin
                  fmt_err_in = 1'b1;
               end else begin
                  in_payload_in = 1'b1;
                  pay_left_in   = len_full;
               end
            end else if (item.last_byte) begin
               // truncated length field
               fmt_err_in = 1'b1;
            end
         end
      end

      bad_arg = (total_in > lpfc_pkg::MAX_TOTAL_BYTES) ||
                (cfg.expected_part_count == '0) ||
                (cfg.expected_part_count > lpfc_pkg::MAX_PARTS);

      if (bad_arg) begin
         result.status = lpfc_pkg::ST_INVALID_ARG;
      end else if (fmt_err_in) begin
         result.status = lpfc_pkg::ST_BAD_FORMAT;
      end else begin
         result.status = lpfc_pkg::ST_VALID;
      end
      result.parts_seen = part_idx_in;

      // record done: start the next one clean
      if (item.last_byte) begin
         in_payload_in = 1'b0;
         len_cnt_in    = '0;
         len_acc_in    = '0;
         pay_left_in   = '0;
         part_idx_in   = '0;
         total_in      = '0;
         fmt_err_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         len_cnt_ff    <= '0;
         len_acc_ff    <= '0;
         pay_left_ff   <= '0;
         part_idx_ff   <= '0;
         total_ff      <= '0;
         fmt_err_ff    <= 1'b0;
      end else if (step_en) begin
         in_payload_ff <= in_payload_in;
         len_cnt_ff    <= len_cnt_in;
         len_acc_ff    <= len_acc_in;
         pay_left_ff   <= pay_left_in;
         part_idx_ff   <= part_idx_in;
         total_ff      <= total_in;
         fmt_err_ff    <= fmt_err_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step_en && item.last_byte |=> part_idx_ff == '0 && total_ff == '0 &&
                                     !in_payload_ff && !fmt_err_ff)
      else $error("record state not cleared after last byte");

   a_len_only_in_header: assert property (@(posedge clock) disable iff (reset)
      len_cnt_ff != '0 |-> !in_payload_ff)
      else $error("length field in progress while in payload");

   a_total_saturates: assert property (@(posedge clock) disable iff (reset)
      total_ff <= lpfc_pkg::MAX_TOTAL_BYTES + lpfc_pkg::TOTAL_W'(1))
      else $error("byte total above saturation value");

endmodule

[hdl/length_prefixed_frame_checker_core.sv]
// top level of the length-prefixed frame checker: input register, parser, result register
// depends on lpfc_pkg, lpfc_cfg_regs, lpfc_parser
//
// usage
//  - req channel: one record byte per transfer (data_byte), last_byte set on the
//    final byte of the record; a record must hold at least one byte
//  - rsp channel: exactly one transfer per record, issued for the last byte,
//    carrying status (valid / invalid argument / invalid wrapped format) and the
//    number of length fields fully read
//  - csr port: single-cycle writes by register index, no read-back; write only
//    while the block is idle (no byte held and no record result pending)
// timing
//  - a byte taken into the input register is parsed when it leaves it, and the
//    result of a record enters the result register as its last byte is parsed
//  - one byte per cycle sustained while no last byte waits on a stalled rsp;
//    the parser is a single registered step (32-bit length assembly and payload
//    countdown) between the input register and the result register
// reset
//  - clears both valid flags, the record state and loads register defaults
//    (expected part count 1, length checking off, expected lengths 0)
// backpressure
//  - while rsp is stalled, non-final bytes keep flowing; a last byte waits in
//    the input register until the result register is free
module length_prefixed_frame_checker_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  lpfc_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output lpfc_pkg::rsp_type                rsp_payload,
   input  logic                             csr_wr_en,
   input  logic [lpfc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lpfc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   lpfc_pkg::cfg_type cfg;
   lpfc_pkg::rsp_type step_result;

   // input register
   logic              in_valid_ff, in_valid_in;
   lpfc_pkg::req_type in_q_ff, in_q_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   lpfc_pkg::rsp_type rsp_q_ff, rsp_q_in;

   logic out_free;
   logic step_en;
   logic req_xfer;

   lpfc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lpfc_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_q_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // result slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;
   // only a last byte needs the result slot
   assign step_en  = in_valid_ff && (!in_q_ff.last_byte || out_free);
   assign req_ready = !in_valid_ff || step_en;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_q_in     = in_q_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         in_q_in     = req_payload;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_q_in     = rsp_q_ff;
      if (step_en && in_q_ff.last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_q_in     = step_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_q_ff  <= in_q_in;
      rsp_q_ff <= rsp_q_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_q_ff;

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      step_en && in_q_ff.last_byte |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten while stalled");

   a_status_code_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_q_ff.status != lpfc_pkg::ST_UNUSED)
      else $error("undefined status code on rsp");

   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && in_q_ff.last_byte && rsp_valid_ff)
      else $error("input stalled without a pending last byte");

endmodule
